@@ src/fsg_pkg.sv @@
// ----------------------------------------------------------------------------
// fsg_pkg: shared types, constants and functions
// Fixed-point constants, pipeline records and helpers for the free-space
// Green's function kernel.
// ----------------------------------------------------------------------------
package fsg_pkg;

  // default depths
  localparam int ROTATION_STAGES_DEF = 24;
  localparam int DIVIDER_STAGES_DEF  = 32;

  // range reduction: quotient of a 64-bit phase by 2*pi fits in 30 bits
  localparam int MOD_CELLS = 30;

  // widths
  localparam int CW  = 34;   // CORDIC datapath, Q2.30 with headroom
  localparam int QW  = 49;   // reciprocal quotient, widest divider
  localparam int RW  = 34;   // divider remainder
  localparam int LZW = 5;

  // constants
  localparam logic [63:0]        TWO_PI_Q32      = 64'd26986075409;
  localparam logic signed [35:0] PI_Q30          = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30     = 36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN   = 34'sd652032874;
  localparam logic [63:0]        INV_FOUR_PI_Q32 = 64'd341782638;
  localparam logic [RW-1:0]      REM_INIT        = 34'h0_8000_0000;
  localparam logic [63:0]        CAP63           = 64'h7FFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  typedef enum logic {
    REG_WAVENUMBER = 1'b0,
    REG_THRESHOLD  = 1'b1
  } fsg_reg_t;

  // item record carried alongside the arithmetic
  typedef struct packed {
    logic             sing;
    logic             flip;
    logic [LZW-1:0]   lz;
    logic [31:0]      m;
    logic [2:0]       vneg;
    logic [2:0][31:0] vmag;
  } fsg_side_t;

  // rotation and division state held by one cell
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [RW-1:0]        rem;
    logic [QW-1:0]        q;
  } fsg_rot_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    r = '0;
    case (i)
      0: r = 34'sh3243F6A8;
      1: r = 34'sh1DAC6705;
      2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;
      4: r = 34'sh03FEAB76;
      5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;
      7: r = 34'sh007FFF55;
      8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD;
      default: begin
        if (i <= 30) r = 34'sd1 <<< (30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  // leading zeros of a non-zero word (zero reads as 31)
  function automatic logic [LZW-1:0] lzc32(input logic [31:0] v);
    logic [LZW-1:0] n;
    n = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // sign and magnitude to saturated 48-bit two's complement
  function automatic logic [47:0] enc48(input logic neg, input logic [127:0] mag);
    logic [47:0] r;
    if (neg) begin
      if (mag > 128'h8000_0000_0000) r = 48'h8000_0000_0000;
      else r = -mag[47:0];
    end else begin
      if (mag > 128'h7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
      else r = mag[47:0];
    end
    return r;
  endfunction

endpackage

@@ src/fsg_mod_cell.sv @@
// ----------------------------------------------------------------------------
// fsg_mod_cell: one step of the phase range reduction
// Subtracts 2*pi scaled by a fixed power of two when the phase allows it.
// ----------------------------------------------------------------------------
module fsg_mod_cell
  import fsg_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] in_p,
  input  fsg_side_t   in_side,
  output logic        out_vld,
  output logic [63:0] out_p,
  output fsg_side_t   out_side
);

  localparam logic [63:0] STEP = TWO_PI_Q32 << SHIFT;

  logic        vld_r;
  logic [63:0] p_r, p_nxt;
  fsg_side_t   side_r;

  // conditional subtract
  assign p_nxt = (in_p >= STEP) ? (in_p - STEP) : in_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      p_r    <= p_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_p    = p_r;
  assign out_side = side_r;

endmodule

@@ src/fsg_rot_cell.sv @@
// ----------------------------------------------------------------------------
// fsg_rot_cell: one CORDIC micro-rotation and one reciprocal bit
// Each cell rotates the vector by +/-atan(2^-IDX) and resolves one quotient
// bit of 1/mantissa; cells past either depth pass that part through.
// ----------------------------------------------------------------------------
module fsg_rot_cell
  import fsg_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int ROT_N = ROTATION_STAGES_DEF,
  parameter int DIV_N = DIVIDER_STAGES_DEF + 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  fsg_rot_t  in_rot,
  input  fsg_side_t in_side,
  output logic      out_vld,
  output fsg_rot_t  out_rot,
  output fsg_side_t out_side
);

  logic      vld_r;
  fsg_rot_t  rot_r, rot_nxt;
  fsg_side_t side_r;

  always_comb begin
    logic signed [CW-1:0] dx, dy;
    logic                 ge;
    logic [RW-1:0]        rem2;
    rot_nxt = in_rot;
    dx      = in_rot.cy >>> IDX;
    dy      = in_rot.cx >>> IDX;
    ge      = in_rot.rem >= {2'b00, in_side.m};
    rem2    = ge ? (in_rot.rem - {2'b00, in_side.m}) : in_rot.rem;
    // rotation towards zero residual angle
    if (IDX < ROT_N) begin
      if (!in_rot.cz[CW-1]) begin
        rot_nxt.cx = in_rot.cx - dx;
        rot_nxt.cy = in_rot.cy + dy;
        rot_nxt.cz = in_rot.cz - atan_q30(IDX);
      end else begin
        rot_nxt.cx = in_rot.cx + dx;
        rot_nxt.cy = in_rot.cy - dy;
        rot_nxt.cz = in_rot.cz + atan_q30(IDX);
      end
    end
    // restoring division step
    if (IDX < DIV_N) begin
      rot_nxt.q   = {in_rot.q[QW-2:0], ge};
      rot_nxt.rem = {rem2[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      rot_r  <= rot_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_rot  = rot_r;
  assign out_side = side_r;

endmodule

@@ src/fsg_mul.sv @@
// ----------------------------------------------------------------------------
// fsg_mul: pipelined 64 x 64 unsigned multiplier
// Four 32-bit partial products, then two adding stages.
// ----------------------------------------------------------------------------
module fsg_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [63:0]  lo_r, hi_r;
  logic [64:0]  mid_r;
  logic [127:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products
      p00_r <= a[31:0]  * b[31:0];
      p01_r <= a[31:0]  * b[63:32];
      p10_r <= a[63:32] * b[31:0];
      p11_r <= a[63:32] * b[63:32];
      // cross terms
      mid_r <= {1'b0, p01_r} + {1'b0, p10_r};
      lo_r  <= p00_r;
      hi_r  <= p11_r;
      // final sum
      p_r   <= {64'b0, lo_r} + ({63'b0, mid_r} << 32) + ({hi_r, 64'b0});
    end
  end

  assign p = p_r;

endmodule

@@ src/free_space_green_gradient.sv @@
// ----------------------------------------------------------------------------
// free_space_green_gradient: free-space Helmholtz Green's function kernel
// Gives G = exp(-jkr)/(4*pi*r) and its far-field gradient per point pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (distance, sep_x/y/z) enter on in_valid/in_ready; one
//   result item (green, gradient, singular flag) leaves on out_valid/out_ready.
//   Wavenumber and singularity threshold are written through cfg_we,
//   cfg_index, cfg_wdata while the pipeline is empty.
// Throughput: one item per cycle while the pipeline is not stalled.
// Pipeline: an entry register, the range-reduction cells, a fold register, the
//   shared CORDIC/divider cell row (as long as the larger of ROTATION_STAGES and
//   DIVIDER_STAGES + 1), post-processing stages with three multiplier banks and
//   the output register.
// Reset: empties the pipeline; wavenumber returns to 1.0, threshold to 1.
// Stall: the whole pipeline holds while the output register is full and
//   out_ready is low; in_ready falls with it.
// Distances below the threshold, or zero, give zeroed values with singular.
// ----------------------------------------------------------------------------
module free_space_green_gradient
  import fsg_pkg::*;
#(
  parameter int ROTATION_STAGES = ROTATION_STAGES_DEF,
  parameter int DIVIDER_STAGES  = DIVIDER_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_distance,
  input  logic signed [31:0] in_sep_x,
  input  logic signed [31:0] in_sep_y,
  input  logic signed [31:0] in_sep_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_green_re,
  output logic signed [47:0] out_green_im,
  output logic signed [47:0] out_grad_x_re,
  output logic signed [47:0] out_grad_x_im,
  output logic signed [47:0] out_grad_y_re,
  output logic signed [47:0] out_grad_y_im,
  output logic signed [47:0] out_grad_z_re,
  output logic signed [47:0] out_grad_z_im,
  output logic               out_singular,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int DIV_N  = DIVIDER_STAGES + 1;
  localparam int NCELL  = (ROTATION_STAGES > DIV_N) ? ROTATION_STAGES : DIV_N;
  localparam int NPOST  = 12;
  localparam logic [6:0] SH_A = 7'(DIVIDER_STAGES + 15);
  localparam logic [6:0] SH_V = 7'(DIVIDER_STAGES + 31);

  typedef struct packed {
    logic             vld;
    logic             sing;
    logic [LZW-1:0]   lz;
    logic [2:0]       vneg;
    logic             gre_neg;
    logic             gim_neg;
    logic [31:0]      acx;
    logic [31:0]      acy;
    logic [QW-1:0]    q;
    logic [2:0][63:0] kv;
    logic [47:0]      a_inv;
    logic [2:0][63:0] vq;
    logic [47:0]      gre_mag;
    logic [47:0]      gim_mag;
    logic [47:0]      g_re;
    logic [47:0]      g_im;
  } post_t;

  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // configuration registers
  logic [31:0] wavenumber_r, threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wavenumber_r <= 32'd65536;
      threshold_r  <= 32'd1;
    end else if (cfg_we) begin
      unique case (fsg_reg_t'(cfg_index))
        REG_WAVENUMBER: wavenumber_r <= cfg_wdata;
        REG_THRESHOLD:  threshold_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // entry stage: phase product, normalisation, vector magnitudes
  logic        a_vld_r;
  logic [63:0] a_p_r;
  fsg_side_t   a_side_r, a_side_nxt;
  logic [2:0][31:0] raw;

  assign raw = {in_sep_z, in_sep_y, in_sep_x};

  always_comb begin
    a_side_nxt.sing = (in_distance == 32'd0) || (in_distance < threshold_r);
    a_side_nxt.flip = 1'b0;
    a_side_nxt.lz   = lzc32(in_distance);
    a_side_nxt.m    = in_distance << a_side_nxt.lz;
    for (int j = 0; j < 3; j++) begin
      a_side_nxt.vneg[j] = raw[j][31];
      a_side_nxt.vmag[j] = raw[j][31] ? -raw[j] : raw[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
    if (adv) begin
      a_p_r    <= {32'b0, wavenumber_r} * {32'b0, in_distance};
      a_side_r <= a_side_nxt;
    end
  end

  // range reduction cells
  logic             m_vld  [0:MOD_CELLS];
  logic [63:0]      m_p    [0:MOD_CELLS];
  fsg_side_t        m_side [0:MOD_CELLS];

  assign m_vld[0]  = a_vld_r;
  assign m_p[0]    = a_p_r;
  assign m_side[0] = a_side_r;

  for (genvar i = 0; i < MOD_CELLS; i++) begin : g_mod
    fsg_mod_cell #(.SHIFT(MOD_CELLS - 1 - i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (m_vld[i]),
      .in_p    (m_p[i]),
      .in_side (m_side[i]),
      .out_vld (m_vld[i+1]),
      .out_p   (m_p[i+1]),
      .out_side(m_side[i+1])
    );
  end

  // fold to [-pi/2, pi/2] and seed the cell row
  logic      r_vld  [0:NCELL];
  fsg_rot_t  r_rot  [0:NCELL];
  fsg_side_t r_side [0:NCELL];
  logic      f_vld_r;
  fsg_rot_t  f_rot_r, f_rot_nxt;
  fsg_side_t f_side_r, f_side_nxt;

  always_comb begin
    logic signed [35:0] ang;
    ang        = {3'b000, m_p[MOD_CELLS][34:2]};
    f_side_nxt = m_side[MOD_CELLS];
    if (ang > PI_Q30) ang = ang - (PI_Q30 <<< 1);
    if (ang > HALF_PI_Q30) begin
      ang             = ang - PI_Q30;
      f_side_nxt.flip = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      ang             = ang + PI_Q30;
      f_side_nxt.flip = 1'b1;
    end
    f_rot_nxt.cx  = CORDIC_GAIN;
    f_rot_nxt.cy  = '0;
    f_rot_nxt.cz  = ang[CW-1:0];
    f_rot_nxt.rem = REM_INIT;
    f_rot_nxt.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= m_vld[MOD_CELLS];
    end
    if (adv) begin
      f_rot_r  <= f_rot_nxt;
      f_side_r <= f_side_nxt;
    end
  end

  assign r_vld[0]  = f_vld_r;
  assign r_rot[0]  = f_rot_r;
  assign r_side[0] = f_side_r;

  // rotation and reciprocal cell row
  for (genvar i = 0; i < NCELL; i++) begin : g_rot
    fsg_rot_cell #(.IDX(i), .ROT_N(ROTATION_STAGES), .DIV_N(DIV_N)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (r_vld[i]),
      .in_rot  (r_rot[i]),
      .in_side (r_side[i]),
      .out_vld (r_vld[i+1]),
      .out_rot (r_rot[i+1]),
      .out_side(r_side[i+1])
    );
  end

  // post-processing stages
  post_t post_r   [0:NPOST-1];
  post_t post_nxt [0:NPOST-1];

  logic [127:0] prod_a, prod_gre, prod_gim;
  logic [127:0] prod_v  [0:2];
  logic [127:0] prod_re [0:2];
  logic [127:0] prod_im [0:2];

  fsg_mul u_mul_a (
    .clk(clk), .en(adv), .a({15'b0, post_r[0].q}), .b(INV_FOUR_PI_Q32), .p(prod_a)
  );
  fsg_mul u_mul_gre (
    .clk(clk), .en(adv), .a({32'b0, post_r[4].acx}), .b({16'b0, post_r[4].a_inv}),
    .p(prod_gre)
  );
  fsg_mul u_mul_gim (
    .clk(clk), .en(adv), .a({32'b0, post_r[4].acy}), .b({16'b0, post_r[4].a_inv}),
    .p(prod_gim)
  );

  for (genvar j = 0; j < 3; j++) begin : g_vec
    fsg_mul u_mul_v (
      .clk(clk), .en(adv), .a(post_r[0].kv[j]), .b({15'b0, post_r[0].q}), .p(prod_v[j])
    );
    fsg_mul u_mul_re (
      .clk(clk), .en(adv), .a(post_r[8].vq[j]), .b({16'b0, post_r[8].gim_mag}),
      .p(prod_re[j])
    );
    fsg_mul u_mul_im (
      .clk(clk), .en(adv), .a(post_r[8].vq[j]), .b({16'b0, post_r[8].gre_mag}),
      .p(prod_im[j])
    );
  end

  always_comb begin
    logic signed [CW-1:0] cxf, cyf;
    logic [6:0]           sh_a, sh_v;
    logic [127:0]         vtmp;
    logic [47:0]          gre_m, gim_m;
    fsg_side_t            sd;
    sd   = r_side[NCELL];
    cxf  = sd.flip ? -r_rot[NCELL].cx : r_rot[NCELL].cx;
    cyf  = sd.flip ? -r_rot[NCELL].cy : r_rot[NCELL].cy;

    // stage 0: sign split, k * |v|
    post_nxt[0]         = post_r[0];
    post_nxt[0].vld     = r_vld[NCELL];
    post_nxt[0].sing    = sd.sing;
    post_nxt[0].lz      = sd.lz;
    post_nxt[0].vneg    = sd.vneg;
    post_nxt[0].gre_neg = cxf[CW-1];
    post_nxt[0].gim_neg = !cyf[CW-1] && (cyf != '0);
    post_nxt[0].acx     = cxf[CW-1] ? 32'(-cxf) : 32'(cxf);
    post_nxt[0].acy     = cyf[CW-1] ? 32'(-cyf) : 32'(cyf);
    post_nxt[0].q       = r_rot[NCELL].q;
    for (int j = 0; j < 3; j++) begin
      post_nxt[0].kv[j] = {32'b0, wavenumber_r} * {32'b0, sd.vmag[j]};
    end

    for (int k = 1; k < NPOST; k++) begin
      post_nxt[k] = post_r[k-1];
    end

    // stage 4: scale back the reciprocal products
    sh_a = SH_A - {2'b00, post_r[3].lz};
    sh_v = SH_V - {2'b00, post_r[3].lz};
    post_nxt[4].a_inv = 48'(prod_a >> sh_a);
    for (int j = 0; j < 3; j++) begin
      vtmp = prod_v[j] >> sh_v;
      post_nxt[4].vq[j] = (|vtmp[127:63]) ? CAP63 : vtmp[63:0];
    end

    // stage 8: magnitudes of G and the saturated G outputs
    gre_m = 48'(prod_gre >> 30);
    gim_m = 48'(prod_gim >> 30);
    post_nxt[8].gre_mag = gre_m;
    post_nxt[8].gim_mag = gim_m;
    post_nxt[8].g_re    = enc48(post_r[7].gre_neg, {80'b0, gre_m});
    post_nxt[8].g_im    = enc48(post_r[7].gim_neg, {80'b0, gim_m});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NPOST; k++) post_r[k].vld <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < NPOST; k++) post_r[k] <= post_nxt[k];
    end
  end

  // output register
  logic             sing_r;
  logic [47:0]      g_re_r, g_im_r;
  logic [2:0][47:0] gr_re_r, gr_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= post_r[NPOST-1].vld;
    end
    if (adv) begin
      sing_r <= post_r[NPOST-1].sing;
      g_re_r <= post_r[NPOST-1].sing ? '0 : post_r[NPOST-1].g_re;
      g_im_r <= post_r[NPOST-1].sing ? '0 : post_r[NPOST-1].g_im;
      for (int j = 0; j < 3; j++) begin
        gr_re_r[j] <= post_r[NPOST-1].sing ? '0 :
          enc48(post_r[NPOST-1].vneg[j] != post_r[NPOST-1].gim_neg, prod_re[j] >> 16);
        gr_im_r[j] <= post_r[NPOST-1].sing ? '0 :
          enc48(post_r[NPOST-1].vneg[j] == post_r[NPOST-1].gre_neg, prod_im[j] >> 16);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_singular  = sing_r;
  assign out_green_re  = g_re_r;
  assign out_green_im  = g_im_r;
  assign out_grad_x_re = gr_re_r[0];
  assign out_grad_x_im = gr_im_r[0];
  assign out_grad_y_re = gr_re_r[1];
  assign out_grad_y_im = gr_im_r[1];
  assign out_grad_z_re = gr_re_r[2];
  assign out_grad_z_im = gr_im_r[2];

endmodule

@@ tb/fsg_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsg_checker: result predictor and comparator for the Green's function kernel
// Watches the input, result and register ports, works out the expected
// result item for each accepted input item and compares field by field.
// ----------------------------------------------------------------------------
module fsg_checker
  import fsg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        in_distance,
  input  logic signed [31:0] in_sep_x,
  input  logic signed [31:0] in_sep_y,
  input  logic signed [31:0] in_sep_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [47:0] out_green_re,
  input  logic signed [47:0] out_green_im,
  input  logic signed [47:0] out_grad_x_re,
  input  logic signed [47:0] out_grad_x_im,
  input  logic signed [47:0] out_grad_y_re,
  input  logic signed [47:0] out_grad_y_im,
  input  logic signed [47:0] out_grad_z_re,
  input  logic signed [47:0] out_grad_z_im,
  input  logic               out_singular,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam int NROT = 24;
  localparam int NDIV = 32;
  localparam longint PI30      = 64'sd3373259426;
  localparam longint HALF_PI30 = 64'sd1686629713;
  localparam longint GAIN30    = 64'sd652032874;
  localparam logic [63:0] TWO_PI32 = 64'd26986075409;
  localparam logic [63:0] INV4PI32 = 64'd341782638;
  localparam logic [63:0] MAG_CAP  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] val [8];
    logic        sing;
  } green_item_t;

  green_item_t green_q [$];
  logic [31:0] k_shadow;
  logic [31:0] thr_shadow;

  function automatic longint arctan_step(int i);
    case (i)
      0: return 64'sh3243F6A8;
      1: return 64'sh1DAC6705;
      2: return 64'sh0FADBAFC;
      3: return 64'sh07F56EA6;
      4: return 64'sh03FEAB76;
      5: return 64'sh01FFD55B;
      6: return 64'sh00FFFAAA;
      7: return 64'sh007FFF55;
      8: return 64'sh003FFFEA;
      9: return 64'sh001FFFFD;
      default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
    endcase
  endfunction

  // truncating multiply-shift, magnitude capped at 2^63-1
  function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p >> sh;
    return (p > {64'b0, MAG_CAP}) ? MAG_CAP : p[63:0];
  endfunction

  function automatic logic [47:0] sat48(logic neg, logic [63:0] mag);
    if (neg) return (mag > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : -mag[47:0];
    return (mag > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
  endfunction

  function automatic green_item_t predict_green(logic [31:0] r, logic [31:0] vx,
                                                logic [31:0] vy, logic [31:0] vz);
    green_item_t res;
    logic [63:0] ph, m, rem, q, a_inv, gre_mag, gim_mag, vmag, vq;
    logic [31:0] vraw [3];
    longint ang, cx, cy, cz, dx, dy;
    logic flip, gre_neg, gim_neg, vneg;
    int lz;
    for (int j = 0; j < 8; j++) res.val[j] = '0;
    res.sing = 1'b1;
    if (r == 0 || r < thr_shadow) return res;
    res.sing = 1'b0;
    // phase k*r reduced modulo 2*pi, folded to +-pi/2
    ph = {32'b0, k_shadow} * {32'b0, r};
    ang = longint'((ph % TWO_PI32) >> 2);
    flip = 1'b0;
    if (ang > PI30) ang -= 2 * PI30;
    if (ang > HALF_PI30) begin
      ang -= PI30;
      flip = 1'b1;
    end else if (ang < -HALF_PI30) begin
      ang += PI30;
      flip = 1'b1;
    end
    // rotation
    cx = GAIN30; cy = 0; cz = ang;
    for (int i = 0; i < NROT; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= arctan_step(i);
      end else begin
        cx += dx; cy -= dy; cz += arctan_step(i);
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    // reciprocal of the normalised distance
    lz = 0;
    while (r[31 - lz] == 1'b0) lz++;
    m = {32'b0, r} << lz;
    rem = 64'h8000_0000;
    q = '0;
    for (int i = 0; i <= NDIV; i++) begin
      q = q << 1;
      if (rem >= m) begin
        rem -= m; q[0] = 1'b1;
      end
      rem = rem << 1;
    end
    a_inv   = mul_trunc(q, INV4PI32, NDIV + 15 - lz);
    gre_mag = mul_trunc(cx < 0 ? -cx : cx, a_inv, 30);
    gim_mag = mul_trunc(cy < 0 ? -cy : cy, a_inv, 30);
    gre_neg = cx < 0;
    gim_neg = cy > 0;
    res.val[0] = sat48(gre_neg, gre_mag);
    res.val[1] = sat48(gim_neg, gim_mag);
    // far-field gradient per component
    vraw[0] = vx; vraw[1] = vy; vraw[2] = vz;
    for (int j = 0; j < 3; j++) begin
      vneg = vraw[j][31];
      vmag = {32'b0, vneg ? -vraw[j] : vraw[j]};
      vq = mul_trunc({32'b0, k_shadow} * vmag, q, NDIV + 31 - lz);
      res.val[2 + 2 * j] = sat48(vneg != gim_neg, mul_trunc(vq, gim_mag, 16));
      res.val[3 + 2 * j] = sat48(vneg == gre_neg, mul_trunc(vq, gre_mag, 16));
    end
    return res;
  endfunction

  assign pending = green_q.size();

  always @(posedge clk) begin
    green_item_t exp_item;
    logic [47:0] got [8];
    string fname [8];
    int errs;
    fname = '{"green_re", "green_im", "grad_x_re", "grad_x_im",
              "grad_y_re", "grad_y_im", "grad_z_re", "grad_z_im"};
    errs = 0;
    if (!rst_n) begin
      k_shadow   <= 32'd65536;
      thr_shadow <= 32'd1;
      fail_count <= 0;
      checked    <= 0;
      green_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_WAVENUMBER) k_shadow <= cfg_wdata;
        else thr_shadow <= cfg_wdata;
      end
      // accepted input item
      if (in_valid && in_ready)
        green_q.push_back(predict_green(in_distance, in_sep_x, in_sep_y, in_sep_z));
      // accepted result item
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (green_q.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          exp_item = green_q.pop_front();
          got = '{out_green_re, out_green_im, out_grad_x_re, out_grad_x_im,
                  out_grad_y_re, out_grad_y_im, out_grad_z_re, out_grad_z_im};
          for (int j = 0; j < 8; j++) begin
            if (got[j] !== exp_item.val[j]) begin
              $error("%s: expected %h, got %h", fname[j], exp_item.val[j], got[j]);
              errs++;
            end
          end
          if (out_singular !== exp_item.sing) begin
            $error("singular: expected %b, got %b", exp_item.sing, out_singular);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ tb/free_space_green_gradient_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_space_green_gradient_tb: stimulus and verdict for the kernel
// Drives directed and random point pairs under several wavenumber and
// threshold settings, with random idling on both sides in all but the last
// random run; the checker predicts every result item and reports mismatches.
// ----------------------------------------------------------------------------
module free_space_green_gradient_tb;
  import fsg_pkg::*;

  localparam int PIPE_WAIT  = 120;
  localparam int DOG_LIMIT  = 3000;
  localparam int RAND_ITEMS = 320;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_distance = '0;
  logic signed [31:0] in_sep_x = '0, in_sep_y = '0, in_sep_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [47:0] out_green_re, out_green_im;
  logic signed [47:0] out_grad_x_re, out_grad_x_im;
  logic signed [47:0] out_grad_y_re, out_grad_y_im;
  logic signed [47:0] out_grad_z_re, out_grad_z_im;
  logic               out_singular;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_WAVENUMBER;
  logic [31:0]        cfg_wdata = '0;
  int                 fail_count, pending, checked;
  bit                 idle_en = 1'b1;
  int                 items_sent = 0;
  int                 settings_run = 0;
  int                 dog = 0;
  int                 stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  free_space_green_gradient u_dut (.*);

  fsg_checker u_chk (.*);

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pair(logic [31:0] d, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
    int gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_distance <= d;
    in_sep_x    <= x;
    in_sep_y    <= y;
    in_sep_z    <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // drain, then write both registers
  task automatic set_regs(logic [31:0] k, logic [31:0] thr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WAVENUMBER;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 3);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] rand_sep();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'sd0 - ($urandom >> $urandom_range(0, 31));
      3:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send_pair(rand_dist(), rand_sep(), rand_sep(), rand_sep());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, edges of every field
    send_pair(32'd0, 32'd0, 32'd0, 32'd0);                  // zero distance
    send_pair(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0);          // at threshold
    send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
    send_pair(32'h0003_243F, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    send_pair(32'h0001_921F, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF); // saturation
    set_regs(32'd0, 32'd0);                                 // zero k, zero threshold
    send_pair(32'd0, 32'd5, 32'd5, 32'd5);
    send_pair(32'd1, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000);
    send_pair(32'h0100_0000, 32'h0100_0000, 32'd0, 32'd0);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);                 // extremes
    send_pair(32'hFFFF_FFFE, 32'd1, 32'd1, 32'd1);          // below threshold
    send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    set_regs(32'hFFFF_FFFF, 32'h0001_0000);
    send_pair(32'h0000_FFFF, 32'd9, 32'd9, 32'd9);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'd3);
    send_pair(32'h0000_0100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);

    // random phases under varied settings
    set_regs(32'd65536, 32'd1);
    random_run(RAND_ITEMS);
    set_regs($urandom >> $urandom_range(0, 31), $urandom_range(0, 70000));
    random_run(RAND_ITEMS);
    set_regs($urandom, $urandom >> $urandom_range(8, 31));
    random_run(RAND_ITEMS);
    set_regs(32'hFFFF_FFFF, 32'd0);
    random_run(RAND_ITEMS);
    set_regs($urandom_range(1, 65536 * 64), $urandom_range(0, 16));
    idle_en = 1'b0;
    random_run(RAND_ITEMS);
    in_valid <= 1'b0;

    // drain and close
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    $display("Sent %0d point pairs under %0d register settings; %0d results checked.",
             items_sent, settings_run + 1, checked);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
src/fsg_pkg.sv
src/fsg_mod_cell.sv
src/fsg_rot_cell.sv
src/fsg_mul.sv
src/free_space_green_gradient.sv
tb/fsg_checker.sv
tb/free_space_green_gradient_tb.sv
